// ----- hw/rtl/spi_rm_pkg.sv -----
// Package for the SPI register access master: command codes, bit stages,
// timing constants and the result record type. No dependencies.
package spi_rm_pkg;

  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 8;
  localparam int TICK_W  = 4;
  localparam int BIT_W   = 3;

  // Timing per bit and per byte, in ticks
  localparam logic [TICK_W-1:0] LOW_TICKS  = 4'd2;
  localparam logic [TICK_W-1:0] HIGH_TICKS = 4'd2;
  localparam logic [TICK_W-1:0] GAP_TICKS  = 4'd10;

  localparam logic [DATA_W-1:0] READ_FLAG = 8'h80;
  localparam logic [BIT_W-1:0]  LAST_BIT  = 3'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_IDLE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAGE_LOW  = 3'b001,
    STAGE_HIGH = 3'b010,
    STAGE_GAP  = 3'b100
  } stage_t;

  typedef struct packed {
    logic              cs_n;
    logic              sck;
    logic              mosi;
    logic              busy_res;
    logic [DATA_W-1:0] read_data;
    logic              read_done;
    logic              request_dropped;
  } res_t;

endpackage

// ----- hw/rtl/spi_register_access_master.sv -----
// SPI mode-0 master for single register reads and writes, one timing tick
// per input transaction. Depends on spi_rm_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | in_valid / in_stall | cmd, reg_addr, write_data, miso
//  output  | out_valid/out_stall | cs_n, sck, mosi, busy_res, read_data,
//          |                     | read_done, request_dropped
//
// Each accepted transaction is one tick: the serial engine state advances and
// the pin levels after that tick land in the output register (or the skid
// entry) in the same cycle. One transaction per cycle while in_stall is low.
// A two-entry output stage (output register plus skid) lets input flow on
// into the skid under output stall; in_stall is the skid's full flag.
// Reset (rst, synchronous) idles the engine: cs_n high, sck and mosi low.
module spi_register_access_master (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [spi_rm_pkg::CMD_W-1:0]     cmd,
  input  logic [spi_rm_pkg::ADDR_W-1:0]    reg_addr,
  input  logic [spi_rm_pkg::DATA_W-1:0]    write_data,
  input  logic                             miso,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             cs_n,
  output logic                             sck,
  output logic                             mosi,
  output logic                             busy_res,
  output logic [spi_rm_pkg::DATA_W-1:0]    read_data,
  output logic                             read_done,
  output logic                             request_dropped
);
  import spi_rm_pkg::*;

  // Engine state
  logic              active, active_next;
  logic              is_read, is_read_next;
  logic              byte_index, byte_index_next;
  logic [BIT_W-1:0]  bit_index, bit_index_next;
  logic [TICK_W-1:0] phase_ticks, phase_ticks_next;
  logic [DATA_W-1:0] tx_shift, tx_shift_next;
  logic [DATA_W-1:0] second_byte, second_byte_next;
  logic [DATA_W-1:0] rx_shift, rx_shift_next;
  logic [DATA_W-1:0] read_hold, read_hold_next;
  logic              cs_q, cs_next;
  logic              sck_q, sck_next;
  logic              mosi_q, mosi_next;
  stage_t            stage, stage_next;

  logic              request;
  logic              dropped;
  logic              done;
  logic [TICK_W-1:0] stage_len;
  logic              accept;
  res_t              res;

  // Output stage
  res_t              out_res;
  res_t              skid_res;
  logic              skid_valid;
  logic              out_load;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_load = !out_valid || !out_stall;

  always_comb begin
    case (cmd_t'(cmd))
      CMD_WRITE, CMD_READ: request = 1'b1;
      default:             request = 1'b0;
    endcase
  end

  always_comb begin
    unique case (stage)
      STAGE_LOW:  stage_len = LOW_TICKS;
      STAGE_HIGH: stage_len = HIGH_TICKS;
      STAGE_GAP:  stage_len = GAP_TICKS;
      default:    stage_len = GAP_TICKS;
    endcase
  end

  // One tick of the engine. enter_low is spelled out where a new bit starts:
  // sck falls, then mosi is driven (address/write byte) or miso is sampled.
  always_comb begin
    logic enter_low;
    enter_low        = 1'b0;
    active_next      = active;
    is_read_next     = is_read;
    byte_index_next  = byte_index;
    bit_index_next   = bit_index;
    phase_ticks_next = phase_ticks;
    tx_shift_next    = tx_shift;
    second_byte_next = second_byte;
    rx_shift_next    = rx_shift;
    read_hold_next   = read_hold;
    cs_next          = cs_q;
    sck_next         = sck_q;
    mosi_next        = mosi_q;
    stage_next       = stage;
    dropped          = 1'b0;
    done             = 1'b0;

    if (!active) begin
      if (request) begin
        active_next     = 1'b1;
        is_read_next    = (cmd_t'(cmd) == CMD_READ);
        byte_index_next = 1'b0;
        bit_index_next  = '0;
        rx_shift_next   = '0;
        if (cmd_t'(cmd) == CMD_READ) begin
          tx_shift_next    = {1'b0, reg_addr, 1'b0} | READ_FLAG;
          second_byte_next = '0;
        end else begin
          tx_shift_next    = {1'b0, reg_addr, 1'b0};
          second_byte_next = write_data;
        end
        cs_next   = 1'b0;
        enter_low = 1'b1;
      end
    end else begin
      dropped = request;
      if (phase_ticks < stage_len) begin
        phase_ticks_next = phase_ticks + TICK_W'(1);
      end else begin
        unique case (stage)
          STAGE_LOW: begin
            stage_next       = STAGE_HIGH;
            phase_ticks_next = 4'd1;
            sck_next         = 1'b1;
            tx_shift_next    = {tx_shift[DATA_W-2:0], 1'b0};
          end
          STAGE_HIGH: begin
            if (bit_index != LAST_BIT) begin
              bit_index_next = bit_index + BIT_W'(1);
              enter_low      = 1'b1;
            end else begin
              stage_next       = STAGE_GAP;
              phase_ticks_next = 4'd1;
              sck_next         = 1'b0;
            end
          end
          default: begin
            if (!byte_index) begin
              // Gap after the address byte: start the second byte
              byte_index_next = 1'b1;
              bit_index_next  = '0;
              tx_shift_next   = second_byte;
              enter_low       = 1'b1;
            end else begin
              // Gap after the last byte: release chip select
              active_next      = 1'b0;
              stage_next       = STAGE_LOW;
              phase_ticks_next = '0;
              bit_index_next   = '0;
              byte_index_next  = 1'b0;
              cs_next          = 1'b1;
              sck_next         = 1'b0;
              if (is_read) begin
                read_hold_next = rx_shift;
                done           = 1'b1;
              end
            end
          end
        endcase
      end
    end

    if (enter_low) begin
      stage_next       = STAGE_LOW;
      phase_ticks_next = 4'd1;
      sck_next         = 1'b0;
      if (byte_index_next && is_read_next) begin
        mosi_next     = 1'b0;
        rx_shift_next = {rx_shift[DATA_W-2:0], miso};
      end else begin
        mosi_next = tx_shift_next[DATA_W-1];
      end
    end
  end

  assign res = '{
    cs_n:            cs_next,
    sck:             sck_next,
    mosi:            mosi_next,
    busy_res:        active_next,
    read_data:       read_hold_next,
    read_done:       done,
    request_dropped: dropped
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      is_read     <= 1'b0;
      byte_index  <= 1'b0;
      bit_index   <= '0;
      phase_ticks <= '0;
      tx_shift    <= '0;
      second_byte <= '0;
      rx_shift    <= '0;
      read_hold   <= '0;
      cs_q        <= 1'b1;
      sck_q       <= 1'b0;
      mosi_q      <= 1'b0;
      stage       <= STAGE_LOW;
    end else if (accept) begin
      active      <= active_next;
      is_read     <= is_read_next;
      byte_index  <= byte_index_next;
      bit_index   <= bit_index_next;
      phase_ticks <= phase_ticks_next;
      tx_shift    <= tx_shift_next;
      second_byte <= second_byte_next;
      rx_shift    <= rx_shift_next;
      read_hold   <= read_hold_next;
      cs_q        <= cs_next;
      sck_q       <= sck_next;
      mosi_q      <= mosi_next;
      stage       <= stage_next;
    end
  end

  // Output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res;
      end
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign cs_n            = out_res.cs_n;
  assign sck             = out_res.sck;
  assign mosi            = out_res.mosi;
  assign busy_res        = out_res.busy_res;
  assign read_data       = out_res.read_data;
  assign read_done       = out_res.read_done;
  assign request_dropped = out_res.request_dropped;

  // Chip select low exactly while an access is under way
  a_busy_cs: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (busy_res == !cs_n))
    else $error("busy_res and cs_n disagree");

  // A completed read leaves the bus idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_done) |-> (cs_n && !busy_res && !sck))
    else $error("read_done while bus not idle");

  // Serial clock stays low whenever the engine is idle
  a_sck_idle: assert property (@(posedge clk) disable iff (rst)
    !active |-> !sck_q)
    else $error("sck high while idle");

  // Skid entry only fills behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data with output register empty");

endmodule

// ----- tb/spi_register_access_master_check.sv -----
`timescale 1ns / 100ps
// Scoreboard for spi_register_access_master: runs every accepted tick through
// its own model of the serial engine and checks each result field by field.
// Depends on spi_rm_pkg.
module spi_register_access_master_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [spi_rm_pkg::CMD_W-1:0]  cmd,
  input  logic [spi_rm_pkg::ADDR_W-1:0] reg_addr,
  input  logic [spi_rm_pkg::DATA_W-1:0] write_data,
  input  logic                          miso,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          cs_n,
  input  logic                          sck,
  input  logic                          mosi,
  input  logic                          busy_res,
  input  logic [spi_rm_pkg::DATA_W-1:0] read_data,
  input  logic                          read_done,
  input  logic                          request_dropped,
  output int                            mismatches,
  output int                            outstanding,
  output int                            accesses,
  output int                            reads_done,
  output int                            drops
);
  import spi_rm_pkg::*;

  localparam int MAX_REPORTS = 40;

  logic              eng_active, eng_is_read, eng_byte;
  logic [BIT_W-1:0]  eng_bit;
  logic [TICK_W-1:0] eng_phase;
  logic [DATA_W-1:0] eng_tx, eng_second, eng_rx, eng_held;
  stage_t            eng_stage;
  logic              pin_cs, pin_sck, pin_mosi;

  res_t pin_forecast[$];

  function automatic logic [TICK_W-1:0] stage_ticks(input stage_t s);
    case (s)
      STAGE_LOW:  return LOW_TICKS;
      STAGE_HIGH: return HIGH_TICKS;
      default:    return GAP_TICKS;
    endcase
  endfunction

  // sck falls, then mosi is driven or miso sampled
  task automatic begin_low_phase(input logic mi);
    eng_stage = STAGE_LOW;
    eng_phase = 1;
    pin_sck   = 1'b0;
    if (eng_byte && eng_is_read) begin
      pin_mosi = 1'b0;
      eng_rx   = {eng_rx[DATA_W-2:0], mi};
    end else begin
      pin_mosi = eng_tx[DATA_W-1];
    end
  endtask

  task automatic advance_serial_engine(input logic [CMD_W-1:0] c,
                                       input logic [ADDR_W-1:0] a,
                                       input logic [DATA_W-1:0] wd,
                                       input logic mi, output res_t r);
    logic start_req, dropped, done;
    start_req = (c == CMD_WRITE) || (c == CMD_READ);
    dropped   = 1'b0;
    done      = 1'b0;
    if (!eng_active) begin
      if (start_req) begin
        eng_active  = 1'b1;
        eng_is_read = (c == CMD_READ);
        eng_byte    = 1'b0;
        eng_bit     = '0;
        eng_rx      = '0;
        eng_tx      = {a, 1'b0};
        if (eng_is_read) begin
          eng_tx     = eng_tx | READ_FLAG;
          eng_second = '0;
        end else begin
          eng_second = wd;
        end
        pin_cs = 1'b0;
        begin_low_phase(mi);
        accesses++;
      end
    end else begin
      if (start_req) begin
        dropped = 1'b1;
        drops++;
      end
      if (eng_phase < stage_ticks(eng_stage)) begin
        eng_phase = eng_phase + 1'b1;
      end else if (eng_stage == STAGE_LOW) begin
        eng_stage = STAGE_HIGH;
        eng_phase = 1;
        pin_sck   = 1'b1;
        eng_tx    = eng_tx << 1;
      end else if (eng_stage == STAGE_HIGH) begin
        if (eng_bit != LAST_BIT) begin
          eng_bit = eng_bit + 1'b1;
          begin_low_phase(mi);
        end else begin
          eng_stage = STAGE_GAP;
          eng_phase = 1;
          pin_sck   = 1'b0;
        end
      end else if (!eng_byte) begin
        eng_byte = 1'b1;
        eng_bit  = '0;
        eng_tx   = eng_second;
        begin_low_phase(mi);
      end else begin
        // end of the gap after the last byte: release chip select
        eng_active = 1'b0;
        eng_stage  = STAGE_LOW;
        eng_phase  = '0;
        eng_bit    = '0;
        eng_byte   = 1'b0;
        pin_cs     = 1'b1;
        pin_sck    = 1'b0;
        if (eng_is_read) begin
          eng_held = eng_rx;
          done     = 1'b1;
          reads_done++;
        end
      end
    end
    r.cs_n            = pin_cs;
    r.sck             = pin_sck;
    r.mosi            = pin_mosi;
    r.busy_res        = eng_active;
    r.read_data       = eng_held;
    r.read_done       = done;
    r.request_dropped = dropped;
  endtask

  task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      eng_active  = 1'b0;
      eng_is_read = 1'b0;
      eng_byte    = 1'b0;
      eng_bit     = '0;
      eng_phase   = '0;
      eng_tx      = '0;
      eng_second  = '0;
      eng_rx      = '0;
      eng_held    = '0;
      eng_stage   = STAGE_LOW;
      pin_cs      = 1'b1;
      pin_sck     = 1'b0;
      pin_mosi    = 1'b0;
      pin_forecast.delete();
      mismatches  = 0;
      accesses    = 0;
      reads_done  = 0;
      drops       = 0;
    end else begin
      // a result always belongs to an earlier tick, so retire before predicting
      if (out_valid && !out_stall) begin
        if (pin_forecast.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result transaction with no tick outstanding", $time);
        end else begin
          want = pin_forecast.pop_front();
          compare_field("cs_n", want.cs_n, cs_n);
          compare_field("sck", want.sck, sck);
          compare_field("mosi", want.mosi, mosi);
          compare_field("busy_res", want.busy_res, busy_res);
          compare_field("read_data", want.read_data, read_data);
          compare_field("read_done", want.read_done, read_done);
          compare_field("request_dropped", want.request_dropped, request_dropped);
        end
      end
      if (in_valid && !in_stall) begin
        advance_serial_engine(cmd, reg_addr, write_data, miso, want);
        pin_forecast.push_back(want);
      end
    end
    outstanding <= pin_forecast.size();
  end

endmodule

// ----- tb/spi_register_access_master_test.sv -----
`timescale 1ns / 100ps
// Top of the spi_register_access_master testbench: clock, reset, tick stimulus
// with random gaps and output stalls, and the verdict.
// Depends on spi_rm_pkg, the block and spi_register_access_master_check.
module spi_register_access_master_test;
  import spi_rm_pkg::*;

  // Ticks from a start up to and including the last gap tick; the tick after
  // that releases chip select and still counts as busy.
  localparam int ACCESS_TICKS =
    2 * (8 * (int'(LOW_TICKS) + int'(HIGH_TICKS)) + int'(GAP_TICKS));
  localparam int RANDOM_TICKS = 1350;
  localparam int CYCLE_LIMIT  = 600000;

  // cmd code outside the enum: must behave as an idle tick
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {MISO_LOW, MISO_HIGH, MISO_RANDOM} miso_pattern_t;

  logic              clk;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic [CMD_W-1:0]  cmd        = CMD_IDLE;
  logic [ADDR_W-1:0] reg_addr   = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              miso       = 1'b0;
  logic              out_stall  = 1'b0;
  logic              in_stall, out_valid;
  logic              cs_n, sck, mosi, busy_res, read_done, request_dropped;
  logic [DATA_W-1:0] read_data;

  int mismatches, outstanding, accesses, reads_done, drops;
  int ticks_sent  = 0;
  int cycles      = 0;
  bit burst_mode  = 1'b0;
  int stall_left  = 0;
  bit stall_quiet = 1'b0;

  spi_register_access_master dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .reg_addr        (reg_addr),
    .write_data      (write_data),
    .miso            (miso),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cs_n            (cs_n),
    .sck             (sck),
    .mosi            (mosi),
    .busy_res        (busy_res),
    .read_data       (read_data),
    .read_done       (read_done),
    .request_dropped (request_dropped)
  );

  spi_register_access_master_check u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .reg_addr        (reg_addr),
    .write_data      (write_data),
    .miso            (miso),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cs_n            (cs_n),
    .sck             (sck),
    .mosi            (mosi),
    .busy_res        (busy_res),
    .read_data       (read_data),
    .read_done       (read_done),
    .request_dropped (request_dropped),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .accesses        (accesses),
    .reads_done      (reads_done),
    .drops           (drops)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a result.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, a few long ones, and quiet
  // stretches where the receiver never stalls.
  always @(posedge clk) begin
    if ($urandom_range(299) == 0)
      stall_quiet = !stall_quiet;
    if (stall_left > 0)
      stall_left--;
    else if (!stall_quiet && $urandom_range(99) < 25)
      stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
    out_stall <= (stall_left > 0);
  end

  // Sender idle cycles before a tick; zero throughout a burst stretch.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (burst_mode || roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic serial_in(input miso_pattern_t p);
    if (p == MISO_RANDOM)
      return $urandom_range(1);
    return (p == MISO_HIGH);
  endfunction

  // One tick transaction: optional gap, then hold valid and payload until taken.
  // Valid stays high into the next call unless that call opens a gap.
  task automatic drive_tick(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                            input logic [DATA_W-1:0] wd, input logic mi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    reg_addr   <= a;
    write_data <= wd;
    miso       <= mi;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    if ($urandom_range(249) == 0)
      burst_mode = !burst_mode;
  endtask

  // A start tick followed by 'follow' busy ticks. noise_pct of the busy ticks
  // carry a non-idle code (writes and reads get dropped, the unused code not).
  task automatic run_access(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                            input logic [DATA_W-1:0] wd, input int follow,
                            input int noise_pct, input miso_pattern_t p);
    logic [CMD_W-1:0] busy_cmd;
    drive_tick(c, a, wd, serial_in(p));
    repeat (follow) begin
      if ($urandom_range(99) < noise_pct)
        busy_cmd = $urandom_range(3, 1);
      else
        busy_cmd = CMD_IDLE;
      drive_tick(busy_cmd, $urandom, $urandom, serial_in(p));
    end
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0] start_cmd;
    int               follow, roll, goal;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // all-zero write, then the next start lands on the first idle tick
    run_access(CMD_WRITE, '0, 8'h00, ACCESS_TICKS, 0, MISO_LOW);
    // all-ones write
    run_access(CMD_WRITE, '1, 8'hFF, ACCESS_TICKS, 0, MISO_HIGH);
    // read with miso held high: expect 0xFF back
    run_access(CMD_READ, '1, 8'h00, ACCESS_TICKS, 0, MISO_HIGH);
    // read with miso held low; next start hits the chip select release tick
    run_access(CMD_READ, '0, 8'hFF, ACCESS_TICKS - 1, 0, MISO_LOW);
    drive_tick(CMD_WRITE, '1, 8'hFF, 1'b1);
    // write with start requests and unused codes sprinkled over the busy ticks
    run_access(CMD_WRITE, 6'h2A, 8'hA5, ACCESS_TICKS, 25, MISO_RANDOM);
    // unused code while idle starts nothing
    repeat (3) drive_tick(CMD_UNUSED, $urandom, $urandom, 1'b1);
    run_access(CMD_READ, 6'h15, 8'h5A, ACCESS_TICKS + 4, 0, MISO_RANDOM);

    // --- random ---
    // Mostly complete accesses with random content, spaced so that the next
    // start falls on the release tick, the first idle tick or just after;
    // some long idle stretches, and some starts that land mid-access.
    goal = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < goal) begin
      roll = $urandom_range(99);
      if (roll < 45)
        start_cmd = CMD_WRITE;
      else if (roll < 90)
        start_cmd = CMD_READ;
      else if (roll < 95)
        start_cmd = CMD_UNUSED;
      else
        start_cmd = CMD_IDLE;
      roll = $urandom_range(99);
      if (roll < 55)
        follow = ACCESS_TICKS - 1 + $urandom_range(2);
      else if (roll < 85)
        follow = $urandom_range(ACCESS_TICKS + 30, ACCESS_TICKS + 2);
      else
        follow = $urandom_range(ACCESS_TICKS - 2);
      run_access(start_cmd, $urandom, $urandom, follow,
                 ($urandom_range(3) == 0) ? 8 : 0, MISO_RANDOM);
    end

    // --- drain ---
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d ticks driven, %0d accesses started, %0d reads completed,",
             ticks_sent, accesses, reads_done);
    $display("%0d start requests dropped while busy, %0d mismatches",
             drops, mismatches);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
